// ===== src/tfa_pkg.sv =====
`timescale 1ns / 1ps

package tfa_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ADDSUB_W      = 35;
    localparam int MUL_W         = 66;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_RECIP = 3'd4;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // results that bypass the divider
    typedef struct packed {
        logic [2:0]                       op;
        logic                             err;
        logic signed [DATA_W-1:0]         as_lo;
        logic signed [DATA_W-1:0]         as_ce;
        logic signed [DATA_W-1:0]         as_hi;
        logic signed [MUL_W-1:0]          mul_lo;
        logic signed [MUL_W-1:0]          mul_ce;
        logic signed [MUL_W-1:0]          mul_hi;
    } side_t;

    function automatic logic signed [DATA_W-1:0] sat_as(input logic signed [ADDSUB_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > ADDSUB_W'(SAT_MAX)) begin
            r = SAT_MAX;
        end else if (v < ADDSUB_W'(SAT_MIN)) begin
            r = SAT_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_mul(input logic signed [MUL_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > MUL_W'(SAT_MAX)) begin
            r = SAT_MAX;
        end else if (v < MUL_W'(SAT_MIN)) begin
            r = SAT_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/tfa_div.sv =====
`timescale 1ns / 1ps

module tfa_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 33
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num_mag,
    input  logic [DEN_W-1:0] den_mag,
    input  logic             neg,
    output logic [NUM_W-1:0] q_mag,
    output logic             q_neg
);

    // one restoring step per stage, quotient bit per stage
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [NUM_W-1:0] q_reg   [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic             neg_reg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic [DEN_W-1:0] rem_prev;
        logic [NUM_W-1:0] num_prev;
        logic [NUM_W-1:0] q_prev;
        logic [DEN_W-1:0] den_prev;
        logic             neg_prev;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             qbit;

        if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign num_prev = num_mag;
            assign q_prev   = '0;
            assign den_prev = den_mag;
            assign neg_prev = neg;
        end else begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign num_prev = num_reg[k-1];
            assign q_prev   = q_reg[k-1];
            assign den_prev = den_reg[k-1];
            assign neg_prev = neg_reg[k-1];
        end

        assign trial = {rem_prev, num_prev[NUM_W-1]};
        assign diff  = trial - {1'b0, den_prev};
        assign qbit  = (trial >= {1'b0, den_prev});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                num_reg[k] <= {num_prev[NUM_W-2:0], 1'b0};
                q_reg[k]   <= {q_prev[NUM_W-2:0], qbit};
                den_reg[k] <= den_prev;
                neg_reg[k] <= neg_prev;
            end
        end
    end

    assign q_mag = q_reg[NUM_W-1];
    assign q_neg = neg_reg[NUM_W-1];

endmodule

// ===== src/triangular_fuzzy_arith_unit.sv =====
`timescale 1ns / 1ps

// Triangular fuzzy number arithmetic unit. Each input transaction carries an
// operation (add, subtract, multiply, divide, reciprocal of A) and two fuzzy
// numbers given as centre plus left and right spreads in signed fixed point
// with FRAC_BITS fraction bits; each produces exactly one output transaction
// with low, centre and high results saturated to 32 bits and a domain error
// flag. Multiply rounds to nearest (ties up), divide and reciprocal truncate
// toward zero and give zeros with the error flag unless the divisor centre is
// positive and both edge denominators are nonzero. Undefined codes give zero.
// The pipeline takes one transaction per clock while the output side is not
// stalled and consists of three front stages, one stage per quotient bit in
// the restoring dividers (33 + FRAC_BITS bits), and the output register. A
// stall on the output side holds the whole pipeline.

module triangular_fuzzy_arith_unit #(
    parameter int FRAC_BITS = tfa_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[2:0], a_center, a_left, a_right, b_center, b_left, b_right, zero pad
    input  logic [199:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_low[31:0], result_center, result_high, domain_error, zero pad
    output logic [103:0] m_tdata
);

    import tfa_pkg::*;

    localparam int NUM_W = 33 + FRAC_BITS;  // shifted numerator magnitude
    localparam int DEN_W = 33;

    // whole pipeline moves when the output register is free or being taken
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------------------------------------------------------- stage 1
    // input register
    logic                     v1_reg;
    logic [2:0]               op1_reg;
    logic signed [DATA_W-1:0] a_c1_reg, a_l1_reg, a_r1_reg;
    logic signed [DATA_W-1:0] b_c1_reg, b_l1_reg, b_r1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg  <= s_tdata[2:0];
            a_c1_reg <= s_tdata[34:3];
            a_l1_reg <= s_tdata[66:35];
            a_r1_reg <= s_tdata[98:67];
            b_c1_reg <= s_tdata[130:99];
            b_l1_reg <= s_tdata[162:131];
            b_r1_reg <= s_tdata[194:163];
        end
    end

    // ---------------------------------------------------------------- stage 2
    // products, add/subtract sums, divider operands
    logic signed [ADDSUB_W-1:0] as_ce_next, as_lo_next, as_hi_next;
    logic signed [32:0]         n_lo_next, n_ce_next, n_hi_next;
    logic signed [32:0]         d_lo_next, d_ce_next, d_hi_next;

    always_comb begin
        logic signed [ADDSUB_W-1:0] a_c, a_l, a_r, b_c, b_l, b_r;
        a_c = ADDSUB_W'(a_c1_reg);
        a_l = ADDSUB_W'(a_l1_reg);
        a_r = ADDSUB_W'(a_r1_reg);
        b_c = ADDSUB_W'(b_c1_reg);
        b_l = ADDSUB_W'(b_l1_reg);
        b_r = ADDSUB_W'(b_r1_reg);
        as_ce_next = (op1_reg == OP_SUB) ? a_c - b_c : a_c + b_c;
        as_lo_next = as_ce_next - a_l - b_l;
        as_hi_next = as_ce_next + a_r + b_r;

        if (op1_reg == OP_RECIP) begin
            // reciprocal divides one by the edges of the unmodified A
            n_lo_next = 33'sd1 <<< FRAC_BITS;
            n_ce_next = 33'sd1 <<< FRAC_BITS;
            n_hi_next = 33'sd1 <<< FRAC_BITS;
            d_lo_next = 33'(a_c1_reg) + 33'(a_r1_reg);
            d_ce_next = 33'(a_c1_reg);
            d_hi_next = 33'(a_c1_reg) - 33'(a_l1_reg);
        end else begin
            n_lo_next = 33'(a_c1_reg) - 33'(a_l1_reg);
            n_ce_next = 33'(a_c1_reg);
            n_hi_next = 33'(a_c1_reg) + 33'(a_r1_reg);
            d_lo_next = 33'(b_c1_reg) + 33'(b_r1_reg);
            d_ce_next = 33'(b_c1_reg);
            d_hi_next = 33'(b_c1_reg) - 33'(b_l1_reg);
        end
    end

    logic                       v2_reg;
    logic [2:0]                 op2_reg;
    logic signed [63:0]         p_ab2_reg, p_ba1_2_reg, p_ab1_2_reg, p_a1b1_2_reg;
    logic signed [ADDSUB_W-1:0] as_lo2_reg, as_ce2_reg, as_hi2_reg;
    logic signed [32:0]         n_lo2_reg, n_ce2_reg, n_hi2_reg;
    logic signed [32:0]         d_lo2_reg, d_ce2_reg, d_hi2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op2_reg      <= op1_reg;
            p_ab2_reg    <= a_c1_reg * b_c1_reg;
            p_ba1_2_reg  <= b_c1_reg * a_l1_reg;
            p_ab1_2_reg  <= a_c1_reg * b_l1_reg;
            p_a1b1_2_reg <= a_l1_reg * b_l1_reg;
            as_lo2_reg   <= as_lo_next;
            as_ce2_reg   <= as_ce_next;
            as_hi2_reg   <= as_hi_next;
            n_lo2_reg    <= n_lo_next;
            n_ce2_reg    <= n_ce_next;
            n_hi2_reg    <= n_hi_next;
            d_lo2_reg    <= d_lo_next;
            d_ce2_reg    <= d_ce_next;
            d_hi2_reg    <= d_hi_next;
        end
    end

    // ---------------------------------------------------------------- stage 3
    // product sums with rounding, saturation of add/subtract, sign split
    side_t      side_next;
    logic [NUM_W-1:0] nm_lo_next, nm_ce_next, nm_hi_next;
    logic [DEN_W-1:0] dm_lo_next, dm_ce_next, dm_hi_next;
    logic             ng_lo_next, ng_ce_next, ng_hi_next;

    function automatic logic [DEN_W-1:0] mag33(input logic signed [32:0] v);
        return v[32] ? DEN_W'(-v) : DEN_W'(v);
    endfunction

    always_comb begin
        logic signed [MUL_W-1:0] half, ab, ba1, ab1, a1b1;
        logic                    is_div;
        half = MUL_W'(1) <<< (FRAC_BITS - 1);
        ab   = MUL_W'(p_ab2_reg);
        ba1  = MUL_W'(p_ba1_2_reg);
        ab1  = MUL_W'(p_ab1_2_reg);
        a1b1 = MUL_W'(p_a1b1_2_reg);
        is_div = (op2_reg == OP_DIV) || (op2_reg == OP_RECIP);

        side_next.op     = op2_reg;
        side_next.err    = is_div && !((d_ce2_reg > 33'sd0) && (d_lo2_reg != 33'sd0)
                                       && (d_hi2_reg != 33'sd0));
        side_next.as_lo  = sat_as(as_lo2_reg);
        side_next.as_ce  = sat_as(as_ce2_reg);
        side_next.as_hi  = sat_as(as_hi2_reg);
        side_next.mul_lo = (ab - ba1 - ab1 + a1b1 + half) >>> FRAC_BITS;
        side_next.mul_ce = (ab + half) >>> FRAC_BITS;
        side_next.mul_hi = (ab + ba1 + ab1 + a1b1 + half) >>> FRAC_BITS;

        nm_lo_next = {mag33(n_lo2_reg), {FRAC_BITS{1'b0}}};
        nm_ce_next = {mag33(n_ce2_reg), {FRAC_BITS{1'b0}}};
        nm_hi_next = {mag33(n_hi2_reg), {FRAC_BITS{1'b0}}};
        dm_lo_next = mag33(d_lo2_reg);
        dm_ce_next = mag33(d_ce2_reg);
        dm_hi_next = mag33(d_hi2_reg);
        ng_lo_next = n_lo2_reg[32] ^ d_lo2_reg[32];
        ng_ce_next = n_ce2_reg[32] ^ d_ce2_reg[32];
        ng_hi_next = n_hi2_reg[32] ^ d_hi2_reg[32];
    end

    logic             v3_reg;
    side_t            side3_reg;
    logic [NUM_W-1:0] nm_lo3_reg, nm_ce3_reg, nm_hi3_reg;
    logic [DEN_W-1:0] dm_lo3_reg, dm_ce3_reg, dm_hi3_reg;
    logic             ng_lo3_reg, ng_ce3_reg, ng_hi3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side3_reg  <= side_next;
            nm_lo3_reg <= nm_lo_next;
            nm_ce3_reg <= nm_ce_next;
            nm_hi3_reg <= nm_hi_next;
            dm_lo3_reg <= dm_lo_next;
            dm_ce3_reg <= dm_ce_next;
            dm_hi3_reg <= dm_hi_next;
            ng_lo3_reg <= ng_lo_next;
            ng_ce3_reg <= ng_ce_next;
            ng_hi3_reg <= ng_hi_next;
        end
    end

    // ---------------------------------------------------------- divider stages
    logic [NUM_W-1:0] q_lo, q_ce, q_hi;
    logic             qn_lo, qn_ce, qn_hi;

    tfa_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_lo (
        .aclk(aclk), .en(adv), .num_mag(nm_lo3_reg), .den_mag(dm_lo3_reg),
        .neg(ng_lo3_reg), .q_mag(q_lo), .q_neg(qn_lo)
    );
    tfa_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_ce (
        .aclk(aclk), .en(adv), .num_mag(nm_ce3_reg), .den_mag(dm_ce3_reg),
        .neg(ng_ce3_reg), .q_mag(q_ce), .q_neg(qn_ce)
    );
    tfa_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_hi (
        .aclk(aclk), .en(adv), .num_mag(nm_hi3_reg), .den_mag(dm_hi3_reg),
        .neg(ng_hi3_reg), .q_mag(q_hi), .q_neg(qn_hi)
    );

    // delay line keeping the other results and valid bits aligned with the dividers
    side_t side_reg [NUM_W];
    logic  vd_reg   [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_delay
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vd_reg[k] <= 1'b0;
            end else if (adv) begin
                vd_reg[k] <= (k == 0) ? v3_reg : vd_reg[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg[k] <= (k == 0) ? side3_reg : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // ----------------------------------------------------------- output stage
    function automatic logic signed [DATA_W-1:0] sat_q(input logic [NUM_W-1:0] q,
                                                       input logic n);
        logic signed [DATA_W-1:0] r;
        if (n) begin
            r = (q > NUM_W'(33'h080000000)) ? SAT_MIN : -(q[DATA_W-1:0]);
        end else begin
            r = (q > NUM_W'(33'h07fffffff)) ? SAT_MAX : q[DATA_W-1:0];
        end
        return r;
    endfunction

    side_t                    side_out;
    logic signed [DATA_W-1:0] lo_next, ce_next, hi_next;
    logic                     err_next;

    assign side_out = side_reg[NUM_W-1];

    always_comb begin
        lo_next  = '0;
        ce_next  = '0;
        hi_next  = '0;
        err_next = 1'b0;
        case (side_out.op)
            OP_ADD, OP_SUB: begin
                lo_next = side_out.as_lo;
                ce_next = side_out.as_ce;
                hi_next = side_out.as_hi;
            end
            OP_MUL: begin
                lo_next = sat_mul(side_out.mul_lo);
                ce_next = sat_mul(side_out.mul_ce);
                hi_next = sat_mul(side_out.mul_hi);
            end
            OP_DIV, OP_RECIP: begin
                err_next = side_out.err;
                if (!side_out.err) begin
                    lo_next = sat_q(q_lo, qn_lo);
                    ce_next = sat_q(q_ce, qn_ce);
                    hi_next = sat_q(q_hi, qn_hi);
                end
            end
            default: begin
                err_next = 1'b0;
            end
        endcase
    end

    logic                     m_tvalid_reg;
    logic signed [DATA_W-1:0] lo_reg, ce_reg, hi_reg;
    logic                     err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= vd_reg[NUM_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lo_reg  <= lo_next;
            ce_reg  <= ce_next;
            hi_reg  <= hi_next;
            err_reg <= err_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, err_reg, hi_reg, ce_reg, lo_reg};

`ifndef SYNTHESIS
    // an error transaction carries zero results
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && err_reg |-> (lo_reg == '0) && (ce_reg == '0) && (hi_reg == '0))
        else $error("domain error with nonzero result");

    // the pipeline only moves when the output slot is free or being taken
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow output slot");

    // a stall freezes the front stage valid
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(v1_reg) && $stable(v3_reg))
        else $error("pipeline moved during stall");

    // error flag only from divide and reciprocal
    a_err_op: assert property (@(posedge aclk) disable iff (!aresetn)
        vd_reg[NUM_W-1] && side_out.err |-> (side_out.op == OP_DIV) || (side_out.op == OP_RECIP))
        else $error("error flag on non-divide operation");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tfa_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int HALF_PERIOD = 10;
    // latency of the pipeline at the default fraction width
    localparam int PIPE_LAT = 37 + FB;
    localparam int N_RANDOM = 1150;
    // undefined operation codes
    localparam logic [2:0] OP_UNDEF_5 = 3'd5;
    localparam logic [2:0] OP_UNDEF_6 = 3'd6;
    localparam logic [2:0] OP_UNDEF_7 = 3'd7;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [199:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;

    triangular_fuzzy_arith_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    logic [199:0] pending_ops[$];
    logic [96:0]  expected_triples[$];
    int           n_errors = 0;
    int           n_results = 0;
    bit           in_fire = 1'b0;
    bit           stim_done = 1'b0;
    int           send_gap = 0;
    int           recv_gap = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;

    function automatic logic [199:0] pack_op(logic [2:0] op,
                                             logic signed [31:0] ac, logic signed [31:0] al,
                                             logic signed [31:0] ar, logic signed [31:0] bc,
                                             logic signed [31:0] bl, logic signed [31:0] br);
        return {5'd0, br, bl, bc, ar, al, ac, op};
    endfunction

    function automatic logic signed [31:0] clamp(logic signed [95:0] v);
        if (v > 96'sd2147483647) begin
            return SAT_MAX;
        end else if (v < -96'sd2147483648) begin
            return SAT_MIN;
        end
        return v[31:0];
    endfunction

    // rounds a Q(2F) sum to nearest, ties towards plus infinity
    function automatic logic signed [95:0] round_q(logic signed [95:0] v);
        return (v + (96'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    function automatic logic signed [95:0] qdiv(longint num, longint den);
        longint q;
        q = (num * (64'sd1 <<< FB)) / den;
        return 96'(q);
    endfunction

    // expected {error, high, centre, low} for one operation
    function automatic logic [96:0] fuzzy_result(logic [199:0] d);
        logic [2:0] op;
        longint ac, al, ar, bc, bl, br, dl, dh;
        logic signed [95:0] lo, ce, hi, ab, ba1, ab1, a1b1;
        logic err;
        op = d[2:0];
        ac = longint'($signed(d[34:3]));
        al = longint'($signed(d[66:35]));
        ar = longint'($signed(d[98:67]));
        bc = longint'($signed(d[130:99]));
        bl = longint'($signed(d[162:131]));
        br = longint'($signed(d[194:163]));
        lo = '0; ce = '0; hi = '0; err = 1'b0;
        case (op)
            OP_ADD: begin
                ce = 96'(ac + bc);
                lo = ce - 96'(al) - 96'(bl);
                hi = ce + 96'(ar) + 96'(br);
            end
            OP_SUB: begin
                ce = 96'(ac - bc);
                lo = ce - 96'(al) - 96'(bl);
                hi = ce + 96'(ar) + 96'(br);
            end
            OP_MUL: begin
                ab   = 96'(ac * bc);
                ba1  = 96'(bc * al);
                ab1  = 96'(ac * bl);
                a1b1 = 96'(al * bl);
                lo = round_q(ab - ba1 - ab1 + a1b1);
                hi = round_q(ab + ba1 + ab1 + a1b1);
                ce = round_q(ab);
            end
            OP_DIV: begin
                dl = bc + br;
                dh = bc - bl;
                if (bc > 0 && dl != 0 && dh != 0) begin
                    lo = qdiv(ac - al, dl);
                    ce = qdiv(ac, bc);
                    hi = qdiv(ac + ar, dh);
                end else begin
                    err = 1'b1;
                end
            end
            OP_RECIP: begin
                dl = ac + ar;
                dh = ac - al;
                if (ac > 0 && dl != 0 && dh != 0) begin
                    lo = qdiv(64'sd1 <<< FB, dl);
                    ce = qdiv(64'sd1 <<< FB, ac);
                    hi = qdiv(64'sd1 <<< FB, dh);
                end else begin
                    err = 1'b1;
                end
            end
            default: ;
        endcase
        return {err, clamp(hi), clamp(ce), clamp(lo)};
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d: %s got %h expected %h", n_results, field, got, want);
        n_errors++;
    endtask

    // operand value: mostly small magnitudes, sometimes extremes or fully random
    function automatic logic signed [31:0] rand_val();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return SAT_MAX;
            1: return SAT_MIN;
            2, 3: return $urandom();
            4: return 32'($signed($urandom_range(0, 64)) - 32) <<< FB;
            default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // directed cases followed by random operations
    initial begin
        logic [2:0] op;
        logic signed [31:0] ac, al, ar, bc, bl, br;
        // extremes through add and subtract, saturating both ways
        pending_ops.push_back(pack_op(OP_ADD, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MAX));
        pending_ops.push_back(pack_op(OP_ADD, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MIN));
        pending_ops.push_back(pack_op(OP_SUB, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MAX));
        pending_ops.push_back(pack_op(OP_SUB, 32'sh0003_0000, 32'sh0000_8000, 32'sh0001_0000,
                                      32'sh0001_0000, 32'sh0000_4000, 32'sh0000_2000));
        // multiply extremes, and a half-lsb tie in each sign
        pending_ops.push_back(pack_op(OP_MUL, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
        pending_ops.push_back(pack_op(OP_MUL, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN));
        pending_ops.push_back(pack_op(OP_MUL, 32'sd1, 32'sd1, 32'sd0, 32'sh0000_8000, 32'sd0, 32'sd0));
        pending_ops.push_back(pack_op(OP_MUL, -32'sd1, 32'sd0, 32'sd0, 32'sh0000_8000, 32'sd0, 32'sd0));
        pending_ops.push_back(pack_op(OP_MUL, 32'sh0002_8000, 32'sh0000_4000, 32'sh0000_1000,
                                      -32'sh0001_2000, 32'sh0000_0800, 32'sh0000_0100));
        // divide: good case, centre zero and negative, each edge denominator zero
        pending_ops.push_back(pack_op(OP_DIV, 32'sh0006_0000, 32'sh0001_0000, 32'sh0002_0000,
                                      32'sh0002_0000, 32'sh0000_8000, 32'sh0000_8000));
        pending_ops.push_back(pack_op(OP_DIV, Q_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd5));
        pending_ops.push_back(pack_op(OP_DIV, Q_ONE, 32'sd0, 32'sd0, -Q_ONE, 32'sd0, 32'sd0));
        pending_ops.push_back(pack_op(OP_DIV, Q_ONE, 32'sd0, 32'sd0, Q_ONE, 32'sd0, -Q_ONE));
        pending_ops.push_back(pack_op(OP_DIV, Q_ONE, 32'sd0, 32'sd0, Q_ONE, Q_ONE, 32'sd0));
        pending_ops.push_back(pack_op(OP_DIV, SAT_MAX, SAT_MIN, SAT_MAX, 32'sd1, SAT_MIN, 32'sd1));
        pending_ops.push_back(pack_op(OP_DIV, SAT_MIN, SAT_MAX, SAT_MIN, 32'sd1, 32'sd2, SAT_MIN));
        // reciprocal: good case, centre not positive, each edge zero, tiny centre
        pending_ops.push_back(pack_op(OP_RECIP, 32'sh0004_0000, 32'sh0001_0000, 32'sh0002_0000,
                                      32'sd0, 32'sd0, 32'sd0));
        pending_ops.push_back(pack_op(OP_RECIP, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
        pending_ops.push_back(pack_op(OP_RECIP, SAT_MIN, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
        pending_ops.push_back(pack_op(OP_RECIP, Q_ONE, 32'sd0, -Q_ONE, 32'sd0, 32'sd0, 32'sd0));
        pending_ops.push_back(pack_op(OP_RECIP, Q_ONE, Q_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
        pending_ops.push_back(pack_op(OP_RECIP, 32'sd1, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
        // undefined codes give zeros
        pending_ops.push_back(pack_op(OP_UNDEF_5, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                                      SAT_MAX));
        pending_ops.push_back(pack_op(OP_UNDEF_6, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        pending_ops.push_back(pack_op(OP_UNDEF_7, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                                      SAT_MIN));
        for (int i = 0; i < N_RANDOM; i++) begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
            ac = rand_val(); al = rand_val(); ar = rand_val();
            bc = rand_val(); bl = rand_val(); br = rand_val();
            // keep most divisions inside the valid domain
            if (op == OP_DIV && $urandom_range(0, 3) != 0) begin
                bc = 32'($urandom_range(1, 32'h7fff_ffff));
            end
            if (op == OP_RECIP && $urandom_range(0, 3) != 0) begin
                ac = 32'($urandom_range(1, 32'h7fff_ffff));
            end
            pending_ops.push_back(pack_op(op, ac, al, ar, bc, bl, br));
        end
    end

    // input transaction accepted: predict its result
    always @(posedge aclk) begin
        if (aresetn) begin
            in_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                expected_triples.push_back(fuzzy_result(s_tdata));
            end
        end
    end

    // driver: new data only after the previous transaction is taken
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !in_fire) begin
                // hold current transaction
            end else if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_ops.size() > 0) begin
                s_tdata  <= pending_ops.pop_front();
                s_tvalid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                s_tvalid  <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // receiver: random stalls plus one long hold-off that backs up the pipeline
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_left > 0) begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && n_results == 300) begin
                m_tready  <= 1'b0;
                hold_left <= 4 * PIPE_LAT;
                hold_done <= 1'b1;
            end else if (recv_gap > 0) begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    recv_gap <= pick_gap();
                end
            end
        end
    end

    // monitor: compare each output transaction with the oldest prediction
    always @(posedge aclk) begin
        logic [96:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_triples.size() == 0) begin
                $display("unexpected output transaction %h", m_tdata);
                n_errors++;
            end else begin
                want = expected_triples.pop_front();
                if (m_tdata[31:0] !== want[31:0])
                    report_mismatch("low", m_tdata[31:0], want[31:0]);
                if (m_tdata[63:32] !== want[63:32])
                    report_mismatch("centre", m_tdata[63:32], want[63:32]);
                if (m_tdata[95:64] !== want[95:64])
                    report_mismatch("high", m_tdata[95:64], want[95:64]);
                if (m_tdata[96] !== want[96])
                    report_mismatch("error", 32'(m_tdata[96]), 32'(want[96]));
            end
            n_results <= n_results + 1;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        wait (stim_done && expected_triples.size() == 0);
        repeat (2 * PIPE_LAT) @(posedge aclk);
        if (n_errors == 0 && expected_triples.size() == 0) begin
            $display("** triangular_fuzzy_arith_unit: PASSED **");
        end else begin
            $display("** triangular_fuzzy_arith_unit: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("timeout waiting for output transactions");
        $display("** triangular_fuzzy_arith_unit: FAILED **");
        $finish;
    end

endmodule
